// ===== design/udcps_pkg.sv =====
package udcps_pkg;

  // Counter range and the value the count wraps to on a downward step from zero.
  localparam int unsigned CountDepth = 100;
  localparam logic [6:0]  CountTop   = 7'd99;

  // Temperature mapping: (code - Offset) * Gain / Divisor - Base.
  localparam int unsigned TempCodeOffset = 20;
  localparam int unsigned TempGain       = 165;
  localparam int unsigned TempDivisor    = 338;
  localparam int unsigned TempBase       = 40;

  // Reciprocal scale: the quotient is (magnitude * TempScale) >> TempShift.
  // Rounding the scale up is exact for every magnitude below 1024.
  localparam int unsigned TempShift = 20;
  localparam int unsigned TempScale =
      ((TempGain << TempShift) + TempDivisor - 1) / TempDivisor;
  localparam int unsigned TempScaleW = $clog2(TempScale + 1);

  typedef logic [6:0]                 count_t;
  typedef count_t [CountDepth-1:0]    count_tab_t;
  typedef logic [3:0]                 digit_t;
  typedef digit_t [CountDepth-1:0]    digit_tab_t;
  typedef logic [6:0]                 segments_t;

  // Segment patterns a..g for the decimal digits, bit 0 is segment a.
  localparam segments_t [9:0] SegTable = {
    7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
  };

  // Trial division by repeated subtraction, evaluated at elaboration only.
  function automatic logic is_prime_f(int unsigned v);
    logic        prime;
    int unsigned rem;
    prime = (v >= 2);
    for (int unsigned d = 2; d * d <= v; d++) begin
      rem = v;
      while (rem >= d) begin
        rem = rem - d;
      end
      if (rem == 0) begin
        prime = 1'b0;
      end
    end
    return prime;
  endfunction

  // One wrapping step by one in the given direction.
  function automatic int unsigned step_one_f(int unsigned v, logic dir_up);
    int unsigned n;
    if (dir_up) begin
      n = (v >= CountDepth - 1) ? 0 : v + 1;
    end else begin
      n = (v == 0) ? CountDepth - 1 : v - 1;
    end
    return n;
  endfunction

  // Table of the adjacent prime in one direction for every count, with wrap.
  function automatic count_tab_t build_prime_step_f(logic dir_up);
    count_tab_t  tab;
    int unsigned n;
    logic        found;
    for (int unsigned v = 0; v < CountDepth; v++) begin
      n     = v;
      found = 1'b0;
      for (int unsigned g = 0; g <= CountDepth; g++) begin
        if (!found) begin
          n     = step_one_f(n, dir_up);
          found = is_prime_f(n);
        end
      end
      tab[v] = count_t'(n);
    end
    return tab;
  endfunction

  function automatic logic [CountDepth-1:0] build_prime_flags_f();
    logic [CountDepth-1:0] flags;
    for (int unsigned v = 0; v < CountDepth; v++) begin
      flags[v] = is_prime_f(v);
    end
    return flags;
  endfunction

  // Decimal digit tables: tens when sel_tens is set, units otherwise.
  function automatic digit_tab_t build_digit_f(logic sel_tens);
    digit_tab_t  tab;
    int unsigned tens;
    int unsigned units;
    for (int unsigned v = 0; v < CountDepth; v++) begin
      tens  = 0;
      units = v;
      while (units >= 10) begin
        units = units - 10;
        tens  = tens + 1;
      end
      tab[v] = sel_tens ? digit_t'(tens) : digit_t'(units);
    end
    return tab;
  endfunction

  localparam count_tab_t            NextPrime  = build_prime_step_f(1'b1);
  localparam count_tab_t            PrevPrime  = build_prime_step_f(1'b0);
  localparam logic [CountDepth-1:0] PrimeFlags = build_prime_flags_f();
  localparam digit_tab_t            TensDigit  = build_digit_f(1'b1);
  localparam digit_tab_t            UnitsDigit = build_digit_f(1'b0);

endpackage

// ===== design/updown_counter_prime_step_display.sv =====
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i / in_stall_o up_level_i, down_level_i, prime_mode_i,
//                                              sensor_code_i[9:0]
// result    out        out_valid_o/out_stall_i count_value_o[6:0], units_segments_o[6:0],
//                                              tens_segments_o[6:0], temperature_o[9:0]
//
// Every accepted beat yields one result beat; it is held first in the input register,
// then in the result register. A beat can be accepted in every cycle unless in_stall_o
// is raised; the single multiplier of the temperature path and the prime tables sit between them.
// Reset puts the count at zero and both previous button levels at released.
// A stall on the result side holds the result register, then the input register, and
// then raises in_stall_o; no beat is dropped.
module updown_counter_prime_step_display (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              up_level_i,
  input  logic              down_level_i,
  input  logic              prime_mode_i,
  input  logic [9:0]        sensor_code_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [6:0]        count_value_o,
  output logic [6:0]        units_segments_o,
  output logic [6:0]        tens_segments_o,
  output logic signed [9:0] temperature_o
);

  localparam int unsigned ProdW = 10 + udcps_pkg::TempScaleW;

  // Handshake and pipeline control.
  logic in_accept;
  logic s2_ready;
  logic s1_adv;
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;

  // Input register payload.
  logic       up_q;
  logic       down_q;
  logic       prime_q;
  logic [9:0] code_q;

  // Counter state.
  udcps_pkg::count_t count_q, count_d;
  logic              up_prev_q, up_prev_d;
  logic              down_prev_q, down_prev_d;

  // Combinational step and result logic.
  logic                 up_edge;
  logic                 down_edge;
  udcps_pkg::count_t    step_plain;
  udcps_pkg::count_t    step_prime;
  logic                 code_low;
  logic [9:0]           temp_mag;
  logic [ProdW-1:0]     temp_prod;
  logic [8:0]           temp_quot;
  logic signed [10:0]   temp_signed;
  logic signed [10:0]   temp_full;
  udcps_pkg::segments_t units_seg_d;
  udcps_pkg::segments_t tens_seg_d;

  // Result register payload.
  udcps_pkg::count_t    out_count_q;
  udcps_pkg::segments_t out_units_q;
  udcps_pkg::segments_t out_tens_q;
  logic signed [9:0]    out_temp_q;

  // The result register frees up when empty or when its beat is taken.
  assign s2_ready    = !out_valid_q || !out_stall_i;
  assign s1_adv      = s1_valid_q && s2_ready;
  assign in_stall_o  = s1_valid_q && !s2_ready;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_accept || (s1_valid_q && !s1_adv);
  assign out_valid_d = s2_ready ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      up_q    <= up_level_i;
      down_q  <= down_level_i;
      prime_q <= prime_mode_i;
      code_q  <= sensor_code_i;
    end
  end

  // Button edges against the previous sample; up wins over down.
  assign up_edge   = !up_q && up_prev_q;
  assign down_edge = !down_q && down_prev_q;

  always_comb begin
    if (up_edge) begin
      step_plain = (count_q >= udcps_pkg::CountTop) ? '0 : count_q + 7'd1;
      step_prime = udcps_pkg::NextPrime[count_q];
    end else begin
      step_plain = (count_q == '0) ? udcps_pkg::CountTop : count_q - 7'd1;
      step_prime = udcps_pkg::PrevPrime[count_q];
    end
  end

  // State advances only when a beat moves into the result register.
  always_comb begin
    count_d     = count_q;
    up_prev_d   = up_prev_q;
    down_prev_d = down_prev_q;
    if (s1_adv) begin
      up_prev_d   = up_q;
      down_prev_d = down_q;
      if (up_edge || down_edge) begin
        count_d = prime_q ? step_prime : step_plain;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      up_prev_q   <= 1'b1;
      down_prev_q <= 1'b1;
    end else begin
      count_q     <= count_d;
      up_prev_q   <= up_prev_d;
      down_prev_q <= down_prev_d;
    end
  end

  // Segment patterns of the new count.
  assign units_seg_d = udcps_pkg::SegTable[udcps_pkg::UnitsDigit[count_d]];
  assign tens_seg_d  = udcps_pkg::SegTable[udcps_pkg::TensDigit[count_d]];

  // Temperature: divide the magnitude by reciprocal multiply, then restore the sign
  // so that the quotient truncates toward zero.
  assign code_low  = code_q < 10'(udcps_pkg::TempCodeOffset);
  assign temp_mag  = code_low ? 10'(udcps_pkg::TempCodeOffset) - code_q
                              : code_q - 10'(udcps_pkg::TempCodeOffset);
  assign temp_prod = ProdW'(temp_mag) * ProdW'(udcps_pkg::TempScale);
  assign temp_quot = temp_prod[udcps_pkg::TempShift +: 9];

  always_comb begin
    temp_signed = code_low ? -$signed({2'b00, temp_quot}) : $signed({2'b00, temp_quot});
    temp_full   = temp_signed - $signed(11'(udcps_pkg::TempBase));
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_count_q <= count_d;
      out_units_q <= units_seg_d;
      out_tens_q  <= tens_seg_d;
      out_temp_q  <= temp_full[9:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign count_value_o    = out_count_q;
  assign units_segments_o = out_units_q;
  assign tens_segments_o  = out_tens_q;
  assign temperature_o    = out_temp_q;

  // The count never leaves its range.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= udcps_pkg::CountTop)
    else $error("count out of range");

  // The input side is held off only while the input register is occupied.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  // The count only moves when a beat advances with a button edge.
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s1_adv || (!up_edge && !down_edge)) |=> $stable(count_q))
    else $error("count changed without a step");

  // A step in prime mode always lands on a prime.
  a_prime_land: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && prime_q && (up_edge || down_edge)) |=> udcps_pkg::PrimeFlags[count_q])
    else $error("prime step landed on a non-prime");

  // The result register takes the new count with the beat.
  a_out_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (out_valid_q && out_count_q == count_q))
    else $error("result count differs from state");

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Segment patterns a..g per decimal digit, bit 0 is segment a.
  localparam udcps_pkg::segments_t DigitSegments [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };
  localparam int Modulus      = 100;
  localparam int SensorOffset = 20;
  localparam int SensorGain   = 165;
  localparam int SensorDiv    = 338;
  localparam int DegreesBase  = 40;
  localparam int CycleLimit   = 400000;
  localparam int DrainCycles  = 8;

  // Button levels are active low.
  localparam logic Pressed  = 1'b0;
  localparam logic Released = 1'b1;

  typedef struct {
    udcps_pkg::count_t    count;
    udcps_pkg::segments_t units;
    udcps_pkg::segments_t tens;
    logic signed [9:0]    temp;
  } readout_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic                 up_level      = Released;
  logic                 down_level    = Released;
  logic                 prime_mode    = 1'b0;
  logic [9:0]           sensor_code   = '0;
  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  udcps_pkg::count_t    count_value;
  udcps_pkg::segments_t units_segments;
  udcps_pkg::segments_t tens_segments;
  logic signed [9:0]    temperature;

  updown_counter_prime_step_display DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .up_level_i      (up_level),
    .down_level_i    (down_level),
    .prime_mode_i    (prime_mode),
    .sensor_code_i   (sensor_code),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .count_value_o   (count_value),
    .units_segments_o(units_segments),
    .tens_segments_o (tens_segments),
    .temperature_o   (temperature)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow of the counter state, advanced once per accepted input beat.
  int       shadow_count   = 0;
  logic     shadow_up_prev = Released;
  logic     shadow_dn_prev = Released;
  readout_t pending_readouts [$];
  int       mismatches     = 0;
  int       burst_left     = 0;
  int       cycle_count    = 0;

  function automatic bit is_prime(int v);
    if (v < 2) return 1'b0;
    for (int d = 2; d * d <= v; d++) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Walk in the step direction, wrapping, until a prime is reached.
  function automatic int adjacent_prime(int v, bit upward);
    int cand;
    cand = v;
    for (int k = 1; k <= Modulus; k++) begin
      cand = upward ? (v + k) % Modulus : (v + Modulus * 2 - k) % Modulus;
      if (is_prime(cand)) return cand;
    end
    return cand;
  endfunction

  function automatic readout_t predict_readout(logic up_lvl, logic down_lvl, logic prime,
                                               logic [9:0] code);
    readout_t r;
    bit       up_fall;
    bit       down_fall;
    int       code_int;
    up_fall   = shadow_up_prev && !up_lvl;
    down_fall = shadow_dn_prev && !down_lvl;
    if (up_fall || down_fall) begin
      if (prime) begin
        shadow_count = adjacent_prime(shadow_count, up_fall);
      end else begin
        shadow_count = up_fall ? (shadow_count + 1) % Modulus
                               : (shadow_count + Modulus - 1) % Modulus;
      end
    end
    shadow_up_prev = up_lvl;
    shadow_dn_prev = down_lvl;
    code_int = int'(code);
    r.count  = udcps_pkg::count_t'(shadow_count);
    r.units  = DigitSegments[shadow_count % 10];
    r.tens   = DigitSegments[shadow_count / 10];
    r.temp   = 10'(((code_int - SensorOffset) * SensorGain) / SensorDiv - DegreesBase);
    return r;
  endfunction

  // Present one sample and hold it until the block takes it; valid stays high.
  task automatic offer_sample(logic up_lvl, logic down_lvl, logic prime, logic [9:0] code);
    in_valid    <= 1'b1;
    up_level    <= up_lvl;
    down_level  <= down_lvl;
    prime_mode  <= prime;
    sensor_code <= code;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    pending_readouts.push_back(predict_readout(up_lvl, down_lvl, prime, code));
  endtask

  // Bursts of back-to-back beats separated by idle gaps of random length.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 40);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending until every outstanding readout has been checked.
  task automatic drain_readouts();
    in_valid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [9:0] pick_code();
    case ($urandom_range(0, 7))
      0:       return 10'd0;
      1:       return 10'd1023;
      2:       return 10'($urandom_range(0, 40));
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic send_paced(logic up_lvl, logic down_lvl, logic prime, logic [9:0] code);
    offer_sample(up_lvl, down_lvl, prime, code);
    pace_sender();
  endtask

  // Single steps with wrap in both directions, both buttons at once, held buttons.
  task automatic test_unit_steps();
    send_paced(Released, Pressed,  1'b0, pick_code());
    send_paced(Released, Released, 1'b0, pick_code());
    send_paced(Pressed,  Released, 1'b0, pick_code());
    send_paced(Released, Released, 1'b0, pick_code());
    send_paced(Pressed,  Pressed,  1'b0, pick_code());
    send_paced(Pressed,  Pressed,  1'b0, pick_code());
    send_paced(Released, Pressed,  1'b0, pick_code());
    send_paced(Released, Released, 1'b0, pick_code());
  endtask

  // Prime stepping, its wrap at both ends, and mode changes that keep the count.
  task automatic test_prime_steps();
    send_paced(Pressed,  Released, 1'b1, pick_code());
    send_paced(Released, Released, 1'b1, pick_code());
    send_paced(Released, Pressed,  1'b1, pick_code());
    send_paced(Released, Released, 1'b1, pick_code());
    send_paced(Pressed,  Released, 1'b1, pick_code());
    send_paced(Released, Released, 1'b1, pick_code());
    send_paced(Released, Pressed,  1'b0, pick_code());
    send_paced(Released, Released, 1'b1, pick_code());
    send_paced(Released, Pressed,  1'b1, pick_code());
  endtask

  // Sensor codes at the ends of the range, around the offset and alternating bits.
  task automatic test_sensor_extremes();
    logic [9:0] codes [8] = '{10'd0, 10'd19, 10'd20, 10'd21, 10'd358, 10'd1023,
                              10'h2AA, 10'h155};
    foreach (codes[i]) send_paced(Released, Released, 1'b0, codes[i]);
  endtask

  // Mostly whole press and release sequences, with some noise and mode flips.
  task automatic test_button_sequences(int beats);
    int   sent;
    bit   upward;
    logic prime;
    logic other;
    sent = 0;
    while (sent < beats) begin
      prime = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          upward = ($urandom_range(0, 2) != 0);
          other  = ($urandom_range(0, 5) == 0) ? Pressed : Released;
          send_paced(Released, Released, prime, pick_code());
          if (upward) begin
            send_paced(Pressed, other, prime, pick_code());
          end else begin
            send_paced(other, Pressed, prime, pick_code());
          end
          sent += 2;
          repeat ($urandom_range(0, 2)) begin
            send_paced(upward ? Pressed : other, upward ? other : Pressed, prime,
                       pick_code());
            sent++;
          end
        end
        6, 7: begin
          send_paced(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), prime,
                     10'($urandom_range(0, 1023)));
          sent++;
        end
        8: begin
          send_paced(Pressed, Pressed, prime, pick_code());
          send_paced(Released, Released, prime, pick_code());
          sent += 2;
        end
        default: begin
          send_paced(Released, Released, !prime, pick_code());
          sent++;
        end
      endcase
      if ($urandom_range(0, 199) == 0) drain_readouts();
    end
  endtask

  // Receiver stall pattern: the style is redrawn at random each time stall_phase wraps.
  int stall_style = 0;
  int stall_phase = 0;
  always @(posedge clk_i) begin
    stall_phase <= (stall_phase == 49) ? 0 : stall_phase + 1;
    if (stall_phase == 49) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ((stall_phase % 8) < 3);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // Compare each result beat with the oldest predicted readout.
  always @(posedge clk_i) begin
    readout_t exp_r;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_readouts.size() == 0) begin
        $error("result beat with no readout expected");
        mismatches++;
      end else begin
        exp_r = pending_readouts.pop_front();
        if (count_value !== exp_r.count) begin
          $error("count_value: expected %0d, got %0d", exp_r.count, count_value);
          mismatches++;
        end
        if (units_segments !== exp_r.units) begin
          $error("units_segments: expected %h, got %h", exp_r.units, units_segments);
          mismatches++;
        end
        if (tens_segments !== exp_r.tens) begin
          $error("tens_segments: expected %h, got %h", exp_r.tens, tens_segments);
          mismatches++;
        end
        if (temperature !== exp_r.temp) begin
          $error("temperature: expected %0d, got %0d", exp_r.temp, temperature);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("updown_counter_prime_step_display regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unit_steps();
    test_prime_steps();
    test_sensor_extremes();
    drain_readouts();
    test_button_sequences(700);
    drain_readouts();
    test_button_sequences(700);
    drain_readouts();
    if (mismatches == 0) begin
      $display("updown_counter_prime_step_display regression: pass");
    end else begin
      $display("updown_counter_prime_step_display regression: fail");
    end
    $finish;
  end

endmodule
